// ===== rtl/core/cmc_pkg.sv =====
`timescale 1ns / 1ps

package cmc_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_FACES    = 128;
    localparam int ID_W             = 16;
    localparam int FACE_W           = 4 * ID_W;

    localparam logic [1:0] MODE_VERTEX = 2'd0;
    localparam logic [1:0] MODE_FACE   = 2'd1;
    localparam logic [1:0] MODE_CHECK  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLOSED        = 3'd0,
        ST_DUP_VERTEX    = 3'd1,
        ST_DUP_FACE      = 3'd2,
        ST_UNUSED_VERTEX = 3'd3,
        ST_ODD_EDGES     = 3'd4,
        ST_BOUNDARY      = 3'd5,
        ST_OVERFLOW      = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DV_I, S_DV_HOLD, S_DV_J, S_DV_CMP,
        S_DF_I, S_DF_HOLD, S_DF_J, S_DF_CMP,
        S_UV_I, S_UV_HOLD, S_UV_J, S_UV_CMP,
        S_BD_I, S_BD_HOLD, S_BD_J, S_BD_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_v;
        logic load_f;
        logic i_clr;
        logic i_inc;
        logic j_clr;
        logic j_from_i;
        logic j_inc;
        logic rd_j;
        logic hold_v;
        logic hold_f;
        logic acc_used;
        logic acc_par;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic ovf;
        logic i_end_v;
        logic i_end_f;
        logic j_end_v;
        logic j_end_f;
        logic vmatch;
        logic fmatch;
        logic used;
        logic par_any;
        logic fodd;
    } t_stat;

endpackage

// ===== rtl/core/cmc_in_if.sv =====
`timescale 1ns / 1ps

interface cmc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] vertex_id;
    logic [15:0] face_id;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;

    modport source (output valid, mode, vertex_id, face_id, corner_a, corner_b, corner_c,
                    input ready);
    modport sink (input valid, mode, vertex_id, face_id, corner_a, corner_b, corner_c,
                  output ready);
endinterface

// ===== rtl/core/cmc_out_if.sv =====
`timescale 1ns / 1ps

interface cmc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;

    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

// ===== rtl/core/cmc_ram.sv =====
`timescale 1ns / 1ps

module cmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/cmc_dpath.sv =====
`timescale 1ns / 1ps

module cmc_dpath import cmc_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_FACES    = DEF_MAX_FACES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  logic [ID_W-1:0] i_vertex_id,
    input  logic [ID_W-1:0] i_face_id,
    input  logic [ID_W-1:0] i_corner_a,
    input  logic [ID_W-1:0] i_corner_b,
    input  logic [ID_W-1:0] i_corner_c,
    output t_stat           o_st
);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int FCW = $clog2(MAX_FACES + 1);
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int FAW = $clog2(MAX_FACES);
    localparam int IW  = (VCW > FCW) ? VCW : FCW;

    // Edge key with the smaller end in the upper half.
    function automatic logic [2*ID_W-1:0] edge_key(logic [ID_W-1:0] p, logic [ID_W-1:0] q);
        return (p < q) ? {p, q} : {q, p};
    endfunction

    logic [VCW-1:0]         r_vcnt;
    logic [FCW-1:0]         r_fcnt;
    logic                   r_ovf;
    logic [IW-1:0]          r_i;
    logic [IW-1:0]          r_j;
    logic [ID_W-1:0]        r_hv;
    logic [ID_W-1:0]        r_hid;
    logic [2:0][2*ID_W-1:0] r_hk;
    logic                   r_used;
    logic [2:0]             r_par;

    logic                   v_full;
    logic                   f_full;
    logic [IW-1:0]          rd_idx;
    logic [ID_W-1:0]        v_rdata;
    logic [FACE_W-1:0]      f_rdata;
    logic [ID_W-1:0]        f_id;
    logic [ID_W-1:0]        f_a;
    logic [ID_W-1:0]        f_b;
    logic [ID_W-1:0]        f_c;
    logic [2:0][2*ID_W-1:0] rk;
    logic [2:0]             hit;

    assign v_full = (r_vcnt == VCW'(MAX_VERTICES));
    assign f_full = (r_fcnt == FCW'(MAX_FACES));
    assign rd_idx = i_cmd.rd_j ? r_j : r_i;

    cmc_ram #(.WIDTH(ID_W), .DEPTH(MAX_VERTICES)) u_vram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_v && !v_full),
        .i_waddr (r_vcnt[VAW-1:0]),
        .i_wdata (i_vertex_id),
        .i_raddr (rd_idx[VAW-1:0]),
        .o_rdata (v_rdata)
    );

    cmc_ram #(.WIDTH(FACE_W), .DEPTH(MAX_FACES)) u_fram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_f && !f_full),
        .i_waddr (r_fcnt[FAW-1:0]),
        .i_wdata ({i_face_id, i_corner_a, i_corner_b, i_corner_c}),
        .i_raddr (rd_idx[FAW-1:0]),
        .o_rdata (f_rdata)
    );

    assign f_id  = f_rdata[4*ID_W-1:3*ID_W];
    assign f_a   = f_rdata[3*ID_W-1:2*ID_W];
    assign f_b   = f_rdata[2*ID_W-1:ID_W];
    assign f_c   = f_rdata[ID_W-1:0];
    assign rk[0] = edge_key(f_a, f_b);
    assign rk[1] = edge_key(f_b, f_c);
    assign rk[2] = edge_key(f_a, f_c);

    // A held edge whose total count over all faces is odd has no partner.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hit[k] = (r_hk[k] == rk[0]) ^ (r_hk[k] == rk[1]) ^ (r_hk[k] == rk[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
            r_fcnt <= '0;
            r_ovf  <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_vcnt <= '0;
                r_fcnt <= '0;
                r_ovf  <= 1'b0;
            end else begin
                if (i_cmd.load_v) begin
                    if (v_full) r_ovf <= 1'b1;
                    else        r_vcnt <= r_vcnt + 1'b1;
                end
                if (i_cmd.load_f) begin
                    if (f_full) r_ovf <= 1'b1;
                    else        r_fcnt <= r_fcnt + 1'b1;
                end
            end
            if (i_cmd.i_clr)      r_i <= '0;
            else if (i_cmd.i_inc) r_i <= r_i + 1'b1;
            if (i_cmd.j_clr)         r_j <= '0;
            else if (i_cmd.j_from_i) r_j <= r_i + 1'b1;
            else if (i_cmd.j_inc)    r_j <= r_j + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_v) begin
            r_hv   <= v_rdata;
            r_used <= 1'b0;
        end else if (i_cmd.acc_used) begin
            r_used <= r_used | (f_a == r_hv) | (f_b == r_hv) | (f_c == r_hv);
        end
        if (i_cmd.hold_f) begin
            r_hid <= f_id;
            r_hk  <= rk;
            r_par <= '0;
        end else if (i_cmd.acc_par) begin
            r_par <= r_par ^ hit;
        end
    end

    assign o_st.ovf     = r_ovf;
    assign o_st.i_end_v = (r_i >= IW'(r_vcnt));
    assign o_st.i_end_f = (r_i >= IW'(r_fcnt));
    assign o_st.j_end_v = (r_j >= IW'(r_vcnt));
    assign o_st.j_end_f = (r_j >= IW'(r_fcnt));
    assign o_st.vmatch  = (v_rdata == r_hv);
    assign o_st.fmatch  = (f_id == r_hid);
    assign o_st.used    = r_used;
    assign o_st.par_any = |r_par;
    assign o_st.fodd    = r_fcnt[0];
endmodule

// ===== rtl/core/cmc_ctrl.sv =====
`timescale 1ns / 1ps

module cmc_ctrl import cmc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    input  logic       i_out_ready,
    input  t_stat      i_st,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output logic [2:0] o_status,
    output t_cmd       o_cmd
);
    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;
    t_cmd    cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_CLOSED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        cmd         = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_mode)
                        MODE_VERTEX: cmd.load_v = 1'b1;
                        MODE_FACE:   cmd.load_f = 1'b1;
                        MODE_CHECK: begin
                            cmd.i_clr = 1'b1;
                            if (i_st.ovf) begin
                                n_status  = ST_OVERFLOW;
                                cmd.clear = 1'b1;
                                n_state   = S_OUT;
                            end else begin
                                n_state = S_DV_I;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DV_I: begin
                if (i_st.i_end_v) begin
                    cmd.i_clr = 1'b1;
                    n_state   = S_DF_I;
                end else begin
                    n_state = S_DV_HOLD;
                end
            end
            S_DV_HOLD: begin
                cmd.hold_v   = 1'b1;
                cmd.j_from_i = 1'b1;
                n_state      = S_DV_J;
            end
            S_DV_J: begin
                if (i_st.j_end_v) begin
                    cmd.i_inc = 1'b1;
                    n_state   = S_DV_I;
                end else begin
                    cmd.rd_j = 1'b1;
                    n_state  = S_DV_CMP;
                end
            end
            S_DV_CMP: begin
                if (i_st.vmatch) begin
                    n_status  = ST_DUP_VERTEX;
                    cmd.clear = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    cmd.j_inc = 1'b1;
                    n_state   = S_DV_J;
                end
            end
            S_DF_I: begin
                if (i_st.i_end_f) begin
                    cmd.i_clr = 1'b1;
                    n_state   = S_UV_I;
                end else begin
                    n_state = S_DF_HOLD;
                end
            end
            S_DF_HOLD: begin
                cmd.hold_f   = 1'b1;
                cmd.j_from_i = 1'b1;
                n_state      = S_DF_J;
            end
            S_DF_J: begin
                if (i_st.j_end_f) begin
                    cmd.i_inc = 1'b1;
                    n_state   = S_DF_I;
                end else begin
                    cmd.rd_j = 1'b1;
                    n_state  = S_DF_CMP;
                end
            end
            S_DF_CMP: begin
                if (i_st.fmatch) begin
                    n_status  = ST_DUP_FACE;
                    cmd.clear = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    cmd.j_inc = 1'b1;
                    n_state   = S_DF_J;
                end
            end
            S_UV_I: begin
                if (i_st.i_end_v) begin
                    if (i_st.fodd) begin
                        // Every face is a triangle: an odd face count means odd edges.
                        n_status  = ST_ODD_EDGES;
                        cmd.clear = 1'b1;
                        n_state   = S_OUT;
                    end else begin
                        cmd.i_clr = 1'b1;
                        n_state   = S_BD_I;
                    end
                end else begin
                    n_state = S_UV_HOLD;
                end
            end
            S_UV_HOLD: begin
                cmd.hold_v = 1'b1;
                cmd.j_clr  = 1'b1;
                n_state    = S_UV_J;
            end
            S_UV_J: begin
                if (i_st.j_end_f) begin
                    if (!i_st.used) begin
                        n_status  = ST_UNUSED_VERTEX;
                        cmd.clear = 1'b1;
                        n_state   = S_OUT;
                    end else begin
                        cmd.i_inc = 1'b1;
                        n_state   = S_UV_I;
                    end
                end else begin
                    cmd.rd_j = 1'b1;
                    n_state  = S_UV_CMP;
                end
            end
            S_UV_CMP: begin
                cmd.acc_used = 1'b1;
                cmd.j_inc    = 1'b1;
                n_state      = S_UV_J;
            end
            S_BD_I: begin
                if (i_st.i_end_f) begin
                    n_status  = ST_CLOSED;
                    cmd.clear = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_BD_HOLD;
                end
            end
            S_BD_HOLD: begin
                cmd.hold_f = 1'b1;
                cmd.j_clr  = 1'b1;
                n_state    = S_BD_J;
            end
            S_BD_J: begin
                if (i_st.j_end_f) begin
                    if (i_st.par_any) begin
                        n_status  = ST_BOUNDARY;
                        cmd.clear = 1'b1;
                        n_state   = S_OUT;
                    end else begin
                        cmd.i_inc = 1'b1;
                        n_state   = S_BD_I;
                    end
                end else begin
                    cmd.rd_j = 1'b1;
                    n_state  = S_BD_CMP;
                end
            end
            S_BD_CMP: begin
                cmd.acc_par = 1'b1;
                cmd.j_inc   = 1'b1;
                n_state     = S_BD_J;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd    = cmd;
    assign o_status = r_status;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    a_clear_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> (n_state == S_OUT))
        else $error("stores cleared outside the end of a check");

    a_ovf_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_mode == MODE_CHECK && i_st.ovf)
        |=> (r_state == S_OUT && r_status == ST_OVERFLOW))
        else $error("overflow not reported first");

    a_out_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_out_ready) |=> (r_state == S_IDLE))
        else $error("result not released after transaction");
endmodule

// ===== rtl/core/closed_mesh_checker.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                                           Transaction
// i_in     in   mode, vertex_id, face_id, corner_a/b/c           valid & ready
// o_out    out  status                                            valid & ready
//
// A load is stored without leaving idle, so loads can follow back to back.
// A check walks the stores with one read port per memory.
// Reset clears counts, indices, the overflow flag and the controller; the memories are not cleared.
// No input is taken while a check runs or its result waits on o_out.

module closed_mesh_checker import cmc_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_FACES    = DEF_MAX_FACES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cmc_in_if.sink    i_in,
    cmc_out_if.source o_out
);
    t_cmd  cmd;
    t_stat st;

    cmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .i_out_ready (o_out.ready),
        .i_st        (st),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_cmd       (cmd)
    );

    cmc_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_FACES    (MAX_FACES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_vertex_id (i_in.vertex_id),
        .i_face_id   (i_in.face_id),
        .i_corner_a  (i_in.corner_a),
        .i_corner_b  (i_in.corner_b),
        .i_corner_c  (i_in.corner_c),
        .o_st        (st)
    );
endmodule
